// ===== rtl/wavhp_pkg.sv =====
// wavhp_pkg: shared types and constants for the wav header chunk parser
// tag words, byte positions of the fixed header, phase and status codes
// no dependencies
package wavhp_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   // byte positions inside the fixed 36-byte header
   localparam logic [31:0] POS_RIFF_END   = 32'd3;
   localparam logic [31:0] POS_WAVE_END   = 32'd11;
   localparam logic [31:0] POS_FMT_END    = 32'd15;
   localparam logic [31:0] POS_FORMAT     = 32'd21;
   localparam logic [31:0] POS_CHANNELS   = 32'd23;
   localparam logic [31:0] POS_RATE       = 32'd27;
   localparam logic [31:0] POS_HEADER_END = 32'd35;

   // chunk header: 4 tag bytes then 4 size bytes
   localparam logic [2:0] CHUNK_TAG_BYTES = 3'd4;
   localparam logic [2:0] CHUNK_LAST      = 3'd7;

   typedef enum logic [3:0] {
      PH_HEADER = 4'b0001,
      PH_CHUNK  = 4'b0010,
      PH_SKIP   = 4'b0100,
      PH_LATCH  = 4'b1000
   } phase_type;

   typedef enum logic [2:0] {
      ST_BUSY  = 3'd0,
      ST_FOUND = 3'd1,
      ST_IDLE  = 3'd2,
      ST_SHORT = 3'd3,
      ST_RIFF  = 3'd4,
      ST_WAVE  = 3'd5,
      ST_FMT   = 3'd6
   } status_type;

   typedef struct packed {
      logic [7:0] file_byte;
      logic       is_final;
   } req_item_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] format_code;
      logic [15:0] channel_count;
      logic [31:0] sample_hz;
      logic [15:0] sample_bits;
      logic [31:0] data_length;
      logic [31:0] data_offset;
   } rsp_item_type;

   // handshake between pipeline stages
   typedef struct packed {
      logic valid;
      logic ready;
   } stage_hs_type;

endpackage

// ===== rtl/wavhp_ifs.sv =====
// wavhp_req_if / wavhp_rsp_if: valid/ready channels of the wav header parser
// payload carried as plain fields; no dependencies
interface wavhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] file_byte;
   logic       is_final;

   modport source(output valid, file_byte, is_final, input ready);
   modport sink(input valid, file_byte, is_final, output ready);
endinterface

interface wavhp_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [15:0] format_code;
   logic [15:0] channel_count;
   logic [31:0] sample_hz;
   logic [15:0] sample_bits;
   logic [31:0] data_length;
   logic [31:0] data_offset;

   modport source(output valid, status, format_code, channel_count, sample_hz,
                  sample_bits, data_length, data_offset, input ready);
   modport sink(input valid, status, format_code, channel_count, sample_hz,
                sample_bits, data_length, data_offset, output ready);
endinterface

// ===== rtl/wavhp_in_stage.sv =====
// wavhp_in_stage: input register of the wav header parser
// depends on wavhp_pkg and wavhp_req_if
module wavhp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   wavhp_req_if.sink             req_chan,
   input  logic                  take,
   output wavhp_pkg::stage_hs_type hs,
   output wavhp_pkg::req_item_type item
);
   import wavhp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   req_item_type item_in;
   logic         load;

   // free when empty or when the held byte moves on this cycle
   assign hs.ready     = !valid_ff || take;
   assign hs.valid     = valid_ff;
   assign req_chan.ready = hs.ready;
   assign load         = req_chan.valid && hs.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (hs.ready) begin
         valid_in = req_chan.valid;
      end
      if (load) begin
         item_in.file_byte = req_chan.file_byte;
         item_in.is_final  = req_chan.is_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item = item_ff;

endmodule

// ===== rtl/wavhp_parser.sv =====
// wavhp_parser: parse state and per-byte update of the wav header parser
// header tag checks, fmt field capture, chunk header walk and skip count
// depends on wavhp_pkg
module wavhp_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  wavhp_pkg::req_item_type item,
   output wavhp_pkg::rsp_item_type result
);
   import wavhp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] size_ff, size_in;
   logic [2:0]  idx_ff, idx_in;
   logic [15:0] format_ff, format_in;
   logic [15:0] chans_ff, chans_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] bits_ff, bits_in;
   status_type  fault_ff, fault_in;
   status_type  latched_ff, latched_in;
   logic [31:0] dsize_ff, dsize_in;
   logic [31:0] doff_ff, doff_in;

   logic [31:0] tag_nx;
   logic [31:0] size_nx;
   logic [31:0] skip_dec;
   status_type  status_nx;

   always_comb begin
      phase_in   = phase_ff;
      pos_in     = pos_ff;
      skip_in    = skip_ff;
      tag_in     = tag_ff;
      size_in    = size_ff;
      idx_in     = idx_ff;
      format_in  = format_ff;
      chans_in   = chans_ff;
      rate_in    = rate_ff;
      bits_in    = bits_ff;
      fault_in   = fault_ff;
      latched_in = latched_ff;
      dsize_in   = dsize_ff;
      doff_in    = doff_ff;
      status_nx  = ST_BUSY;
      skip_dec   = skip_ff - 32'd1;

      tag_nx = tag_ff;
      if (phase_ff == PH_HEADER || (phase_ff == PH_CHUNK && idx_ff < CHUNK_TAG_BYTES)) begin
         tag_nx = {tag_ff[23:0], item.file_byte};
      end
      // little-endian accumulator: newest byte enters at the top
      size_nx = {item.file_byte, size_ff[31:8]};

      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == POS_RIFF_END && tag_nx != TAG_RIFF && fault_in == ST_BUSY) begin
               fault_in = ST_RIFF;
            end
            if (pos_ff == POS_WAVE_END && tag_nx != TAG_WAVE && fault_in == ST_BUSY) begin
               fault_in = ST_WAVE;
            end
            if (pos_ff == POS_FMT_END && tag_nx != TAG_FMT && fault_in == ST_BUSY) begin
               fault_in = ST_FMT;
            end
            if (pos_ff == POS_FORMAT) begin
               format_in = size_nx[31:16];
            end
            if (pos_ff == POS_CHANNELS) begin
               chans_in = size_nx[31:16];
            end
            if (pos_ff == POS_RATE) begin
               rate_in = size_nx;
            end
            if (pos_ff >= POS_HEADER_END) begin
               bits_in = size_nx[31:16];
               if (fault_in != ST_BUSY) begin
                  status_nx = fault_in;
               end else if (item.is_final) begin
                  status_nx = ST_SHORT;
               end else begin
                  phase_in = PH_CHUNK;
                  idx_in   = '0;
               end
            end else if (item.is_final) begin
               status_nx = ST_SHORT;
            end
         end
         PH_CHUNK: begin
            if (idx_ff >= CHUNK_LAST) begin
               if (tag_nx == TAG_DATA) begin
                  dsize_in  = size_nx;
                  doff_in   = pos_ff + 32'd1;
                  status_nx = ST_FOUND;
               end else if (item.is_final) begin
                  status_nx = ST_SHORT;
               end else begin
                  idx_in = '0;
                  // zero size chunk goes straight to the next chunk header
                  if (size_nx != '0) begin
                     skip_in  = size_nx;
                     phase_in = PH_SKIP;
                  end
               end
            end else begin
               idx_in = idx_ff + 3'd1;
               if (item.is_final) begin
                  status_nx = ST_SHORT;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_dec;
            if (item.is_final) begin
               status_nx = ST_SHORT;
            end else if (skip_dec == '0) begin
               phase_in = PH_CHUNK;
               idx_in   = '0;
            end
         end
         PH_LATCH: begin
            status_nx = (latched_ff == ST_FOUND) ? ST_IDLE : latched_ff;
         end
         default: begin
            status_nx = ST_BUSY;
         end
      endcase

      if (phase_ff != PH_LATCH) begin
         tag_in  = tag_nx;
         size_in = size_nx;
         pos_in  = pos_ff + 32'd1;
         if (status_nx != ST_BUSY) begin
            latched_in = status_nx;
            phase_in   = PH_LATCH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         pos_ff     <= '0;
         skip_ff    <= '0;
         tag_ff     <= '0;
         size_ff    <= '0;
         idx_ff     <= '0;
         format_ff  <= '0;
         chans_ff   <= '0;
         rate_ff    <= '0;
         bits_ff    <= '0;
         fault_ff   <= ST_BUSY;
         latched_ff <= ST_BUSY;
         dsize_ff   <= '0;
         doff_ff    <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         skip_ff    <= skip_in;
         tag_ff     <= tag_in;
         size_ff    <= size_in;
         idx_ff     <= idx_in;
         format_ff  <= format_in;
         chans_ff   <= chans_in;
         rate_ff    <= rate_in;
         bits_ff    <= bits_in;
         fault_ff   <= fault_in;
         latched_ff <= latched_in;
         dsize_ff   <= dsize_in;
         doff_ff    <= doff_in;
      end
   end

   always_comb begin
      result.status        = status_nx;
      result.format_code   = format_in;
      result.channel_count = chans_in;
      result.sample_hz     = rate_in;
      result.sample_bits   = bits_in;
      result.data_length   = dsize_in;
      result.data_offset   = doff_in;
   end

   a_latch_holds: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LATCH |=> phase_ff == PH_LATCH)
      else $error("parser left the latched phase");

   a_latched_fields_stable: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_LATCH |=> $stable(dsize_ff) && $stable(doff_ff) && $stable(rate_ff))
      else $error("captured fields changed after latch");

   a_skip_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != '0)
      else $error("skip phase with nothing left to skip");

   a_header_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> pos_ff <= POS_HEADER_END)
      else $error("header phase ran past the fixed header");

   a_found_latches: assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_FOUND |=> phase_ff == PH_LATCH && latched_ff == ST_FOUND)
      else $error("data found without latching");

endmodule

// ===== rtl/wavhp_out_stage.sv =====
// wavhp_out_stage: result register of the wav header parser
// depends on wavhp_pkg and wavhp_rsp_if
module wavhp_out_stage (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  wavhp_pkg::rsp_item_type result,
   output logic                    out_free,
   wavhp_rsp_if.source             rsp_chan
);
   import wavhp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;
   rsp_item_type item_in;

   // room when empty or when the held result transfers this cycle
   assign out_free = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (out_free) begin
         valid_in = load;
      end
      if (load) begin
         item_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign rsp_chan.valid         = valid_ff;
   assign rsp_chan.status        = item_ff.status;
   assign rsp_chan.format_code   = item_ff.format_code;
   assign rsp_chan.channel_count = item_ff.channel_count;
   assign rsp_chan.sample_hz     = item_ff.sample_hz;
   assign rsp_chan.sample_bits   = item_ff.sample_bits;
   assign rsp_chan.data_length   = item_ff.data_length;
   assign rsp_chan.data_offset   = item_ff.data_offset;

endmodule

// ===== rtl/wav_header_chunk_parser.sv =====
// WAV header and chunk parser. Takes one file byte per transfer on req_chan and
// returns one result per byte on rsp_chan: a status code plus the captured fmt
// fields, data chunk size and data start offset. The fixed 36-byte header is
// checked for RIFF, WAVE and "fmt " (first failure reported at the 36th byte),
// then 8-byte chunk headers are walked and non-data bodies skipped by their
// unsigned size. Errors and data-found latch until reset; later bytes return the
// error again, or idle after data found. Throughput is one byte per clock while
// neither side stalls. The transfer loads the input register, then the parse state
// update writes the byte's result into the result register, from which it is
// presented on rsp_chan. Either side may stall at any time.
// depends on wavhp_pkg, wavhp_ifs, wavhp_in_stage, wavhp_parser, wavhp_out_stage
module wav_header_chunk_parser (
   input  logic        clock,
   input  logic        reset,
   wavhp_req_if.sink   req_chan,
   wavhp_rsp_if.source rsp_chan
);
   import wavhp_pkg::*;

   stage_hs_type in_hs;
   req_item_type in_item;
   rsp_item_type result;
   logic         out_free;
   logic         step;

   assign step = in_hs.valid && out_free;

   wavhp_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (step),
      .hs       (in_hs),
      .item     (in_item)
   );

   wavhp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_item),
      .result (result)
   );

   wavhp_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (step),
      .result   (result),
      .out_free (out_free),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== verif/tb_wav_header_chunk_parser.sv =====
// tb_wav_header_chunk_parser: self-checking bench for the wav header chunk parser
// streams one generated wav file through req_chan, predicts and checks every rsp_chan transfer
// depends on wavhp_pkg, wavhp_ifs and the wav_header_chunk_parser rtl
module tb_wav_header_chunk_parser;
   import wavhp_pkg::*;

   typedef enum int {
      ENDING_DATA,
      ENDING_DATA_FINAL,
      ENDING_SHORT_SKIP,
      ENDING_SHORT_CHUNK,
      ENDING_SHORT_HEADER,
      ENDING_BAD_TAG
   } ending_type;

   localparam int TARGET_BYTES = 1000;
   localparam int HOLD_START   = 60;
   localparam int HOLD_CYCLES  = 100;
   localparam int DRAIN_CYCLES = 10;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wavhp_req_if req_chan();
   wavhp_rsp_if rsp_chan();

   wav_header_chunk_parser dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #5 clock = ~clock;

   logic [7:0]   wav_image[$];
   req_item_type file_bytes[$];
   rsp_item_type pending_results[$];
   int           file_length = 0;
   int           bytes_accepted = 0;
   int           results_checked = 0;
   int           mismatch_count = 0;
   int           chunk_count = 0;
   int           hold_left = 0;
   int           sender_burst_left = 0;
   int           sender_gap_left = 0;
   int           receiver_cycles = 0;
   int           pattern_left = 0;
   logic [15:0]  stall_pattern = '1;
   logic         hold_done = 1'b0;
   ending_type   ending;

   // parser mirror state
   phase_type   mir_phase = PH_HEADER;
   logic [31:0] mir_position = '0;
   logic [31:0] mir_skip_left = '0;
   logic [31:0] mir_tag = '0;
   logic [31:0] mir_size = '0;
   logic [2:0]  mir_chunk_index = '0;
   logic [15:0] mir_format = '0;
   logic [15:0] mir_channels = '0;
   logic [31:0] mir_rate = '0;
   logic [15:0] mir_bits = '0;
   logic [31:0] mir_data_length = '0;
   logic [31:0] mir_data_offset = '0;
   status_type  mir_fault = ST_BUSY;
   status_type  mir_latched = ST_BUSY;

   function automatic status_type latch_status(input status_type code);
      mir_latched = code;
      mir_phase = PH_LATCH;
      return code;
   endfunction

   function automatic rsp_item_type parse_byte(input logic [7:0] b, input logic fin);
      rsp_item_type res;
      status_type   st;
      logic [31:0]  pos;
      st = ST_BUSY;
      if (mir_phase == PH_LATCH) begin
         st = (mir_latched == ST_FOUND) ? ST_IDLE : mir_latched;
      end else begin
         pos = mir_position;
         if (mir_phase == PH_HEADER ||
             (mir_phase == PH_CHUNK && mir_chunk_index < CHUNK_TAG_BYTES))
            mir_tag = {mir_tag[23:0], b};
         mir_size = {b, mir_size[31:8]};
         case (mir_phase)
            PH_HEADER: begin
               // first failed tag check wins, reported only at the last header byte
               if (pos == POS_RIFF_END && mir_tag != TAG_RIFF && mir_fault == ST_BUSY)
                  mir_fault = ST_RIFF;
               if (pos == POS_WAVE_END && mir_tag != TAG_WAVE && mir_fault == ST_BUSY)
                  mir_fault = ST_WAVE;
               if (pos == POS_FMT_END && mir_tag != TAG_FMT && mir_fault == ST_BUSY)
                  mir_fault = ST_FMT;
               if (pos == POS_FORMAT)
                  mir_format = mir_size[31:16];
               if (pos == POS_CHANNELS)
                  mir_channels = mir_size[31:16];
               if (pos == POS_RATE)
                  mir_rate = mir_size;
               if (pos >= POS_HEADER_END) begin
                  mir_bits = mir_size[31:16];
                  if (mir_fault != ST_BUSY)
                     st = latch_status(mir_fault);
                  else if (fin)
                     st = latch_status(ST_SHORT);
                  else begin
                     mir_phase = PH_CHUNK;
                     mir_chunk_index = '0;
                  end
               end else if (fin) begin
                  st = latch_status(ST_SHORT);
               end
            end
            PH_CHUNK: begin
               if (mir_chunk_index >= CHUNK_LAST) begin
                  if (mir_tag == TAG_DATA) begin
                     mir_data_length = mir_size;
                     mir_data_offset = pos + 32'd1;
                     st = latch_status(ST_FOUND);
                  end else if (fin) begin
                     st = latch_status(ST_SHORT);
                  end else begin
                     mir_chunk_index = '0;
                     if (mir_size != '0) begin
                        mir_skip_left = mir_size;
                        mir_phase = PH_SKIP;
                     end
                  end
               end else begin
                  mir_chunk_index = mir_chunk_index + 3'd1;
                  if (fin)
                     st = latch_status(ST_SHORT);
               end
            end
            default: begin
               mir_skip_left = mir_skip_left - 32'd1;
               if (fin)
                  st = latch_status(ST_SHORT);
               else if (mir_skip_left == '0) begin
                  mir_phase = PH_CHUNK;
                  mir_chunk_index = '0;
               end
            end
         endcase
         mir_position = pos + 32'd1;
      end
      res.status = st;
      res.format_code = mir_format;
      res.channel_count = mir_channels;
      res.sample_hz = mir_rate;
      res.sample_bits = mir_bits;
      res.data_length = mir_data_length;
      res.data_offset = mir_data_offset;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch at result %0d: %s", $time, results_checked, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // file image builders
   task automatic add_le(input logic [31:0] value, input int nbytes);
      for (int i = 0; i < nbytes; i++)
         wav_image.push_back(value[8*i +: 8]);
   endtask

   task automatic add_tag(input logic [31:0] tag);
      for (int i = 3; i >= 0; i--)
         wav_image.push_back(tag[8*i +: 8]);
   endtask

   function automatic logic [31:0] pick_value(input int bits);
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = '0;
         1: v = '1;
         2: v = $urandom_range(1, 64);
         default: v = $urandom;
      endcase
      return (bits == 16) ? {16'h0, v[15:0]} : v;
   endfunction

   function automatic logic [31:0] pick_chunk_tag();
      logic [31:0] tag;
      case ($urandom_range(0, 3))
         0: tag = $urandom;
         1: tag = TAG_DATA ^ (32'h1 << $urandom_range(0, 31));
         2: tag = TAG_FMT;
         default: begin
            tag = TAG_DATA;
            tag[8*$urandom_range(0, 3) +: 8] = $urandom_range(0, 255);
         end
      endcase
      if (tag == TAG_DATA)
         tag[0] = ~tag[0];
      return tag;
   endfunction

   task automatic add_header(input logic [31:0] riff, input logic [31:0] wave,
                             input logic [31:0] fmt);
      add_tag(riff);
      add_le($urandom, 4);
      add_tag(wave);
      add_tag(fmt);
      add_le(($urandom_range(0, 3) == 0) ? $urandom : 32'd16, 4);
      add_le(pick_value(16), 2);
      add_le(pick_value(16), 2);
      add_le(pick_value(32), 4);
      add_le($urandom, 4);
      add_le($urandom, 2);
      add_le(pick_value(16), 2);
   endtask

   task automatic add_chunk(input logic [31:0] tag, input logic [31:0] size);
      add_tag(tag);
      add_le(size, 4);
      repeat (size) wav_image.push_back($urandom_range(0, 255));
      chunk_count++;
   endtask

   // sender: bursts of random length with random gaps, no gaps while the receiver holds off
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.file_byte <= '0;
         req_chan.is_final <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (sender_gap_left != 0 && hold_left == 0) begin
            sender_gap_left--;
            req_chan.valid <= 1'b0;
         end else if (file_bytes.size() != 0) begin
            req_chan.valid <= 1'b1;
            req_chan.file_byte <= file_bytes[0].file_byte;
            req_chan.is_final <= file_bytes[0].is_final;
            void'(file_bytes.pop_front());
            if (sender_burst_left == 0) begin
               sender_burst_left = $urandom_range(1, 24);
               sender_gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
               sender_burst_left--;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // receiver: rotating 16-bit stall pattern, reloaded after each full rotation, plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         receiver_cycles++;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (!hold_done && receiver_cycles >= HOLD_START) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_left = 16;
               case ($urandom_range(0, 3))
                  0: stall_pattern = '1;
                  1: stall_pattern = $urandom;
                  2: stall_pattern = $urandom & $urandom;
                  default: stall_pattern = $urandom | $urandom;
               endcase
            end
            pattern_left--;
            rsp_chan.ready <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
         end
      end
   end

   // monitor: predict on each input transfer, check each result transfer
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            pending_results.push_back(parse_byte(req_chan.file_byte, req_chan.is_final));
            bytes_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result transfer with nothing expected");
            end else begin
               want = pending_results.pop_front();
               check_field("status", 32'(rsp_chan.status), 32'(want.status));
               check_field("format_code", 32'(rsp_chan.format_code), 32'(want.format_code));
               check_field("channel_count", 32'(rsp_chan.channel_count),
                           32'(want.channel_count));
               check_field("sample_hz", rsp_chan.sample_hz, want.sample_hz);
               check_field("sample_bits", 32'(rsp_chan.sample_bits), 32'(want.sample_bits));
               check_field("data_length", rsp_chan.data_length, want.data_length);
               check_field("data_offset", rsp_chan.data_offset, want.data_offset);
            end
            results_checked++;
         end
      end
   end

   initial begin
      #2000000;
      $display("tb_wav_header_chunk_parser: done, errors");
      $finish;
   end

   initial begin
      int          pick;
      int          cut;
      int          limit;
      int          body;
      logic [31:0] riff;
      logic [31:0] wave;
      logic [31:0] fmt;
      logic [31:0] tag;
      logic [31:0] size;
      logic        has_final;

      pick = $urandom_range(0, 19);
      if (pick <= 5)       ending = ENDING_DATA;
      else if (pick <= 10) ending = ENDING_DATA_FINAL;
      else if (pick <= 13) ending = ENDING_SHORT_SKIP;
      else if (pick <= 16) ending = ENDING_SHORT_CHUNK;
      else if (pick == 17) ending = ENDING_SHORT_HEADER;
      else                 ending = ENDING_BAD_TAG;

      riff = TAG_RIFF;
      wave = TAG_WAVE;
      fmt = TAG_FMT;
      if (ending == ENDING_BAD_TAG) begin
         // any mix of broken tags, so the check order matters
         pick = $urandom_range(1, 7);
         if (pick[0]) riff ^= 32'h1 << $urandom_range(0, 31);
         if (pick[1]) wave ^= 32'h1 << $urandom_range(0, 31);
         if (pick[2]) fmt ^= 32'h1 << $urandom_range(0, 31);
      end
      add_header(riff, wave, fmt);
      has_final = 1'b1;

      case (ending)
         ENDING_SHORT_HEADER: begin
            cut = $urandom_range(1, 35);
            repeat (36 - cut) void'(wav_image.pop_back());
         end
         ENDING_BAD_TAG: begin
            // sometimes the stream also ends inside the header, or right on its last byte
            if ($urandom_range(0, 1) == 0) begin
               cut = ($urandom_range(0, 2) == 0) ? 36 : $urandom_range(1, 35);
               repeat (36 - cut) void'(wav_image.pop_back());
            end else begin
               has_final = 1'b0;
            end
         end
         default: begin
            // directed opening: zero size near miss of the data tag, then a one byte body
            add_chunk(TAG_DATA ^ 32'h0000_0100, 32'd0);
            add_chunk(TAG_FMT, 32'd1);
            add_chunk(pick_chunk_tag(), 32'd0);
            while (wav_image.size() < TARGET_BYTES) begin
               size = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 40);
               add_chunk(pick_chunk_tag(), size);
            end
            case (ending)
               ENDING_DATA, ENDING_DATA_FINAL: begin
                  add_tag(TAG_DATA);
                  add_le(pick_value(32), 4);
                  has_final = (ending == ENDING_DATA_FINAL);
               end
               ENDING_SHORT_SKIP: begin
                  case ($urandom_range(0, 2))
                     0: size = '1;
                     1: size = $urandom | 32'h0001_0000;
                     default: size = $urandom_range(1, 60);
                  endcase
                  add_tag(pick_chunk_tag());
                  add_le(size, 4);
                  limit = (size > 60) ? 60 : int'(size);
                  body = $urandom_range(1, limit);
                  repeat (body) wav_image.push_back($urandom_range(0, 255));
               end
               default: begin
                  // stream ends inside a chunk header, data tag or not
                  if ($urandom_range(0, 1) == 0) begin
                     tag = TAG_DATA;
                     cut = $urandom_range(1, 7);
                  end else begin
                     tag = pick_chunk_tag();
                     cut = $urandom_range(1, 8);
                  end
                  add_tag(tag);
                  add_le($urandom_range(0, 40), 4);
                  repeat (8 - cut) void'(wav_image.pop_back());
               end
            endcase
         end
      endcase

      foreach (wav_image[i])
         file_bytes.push_back('{file_byte: wav_image[i],
                                is_final: has_final && (i == wav_image.size() - 1)});
      // trailing bytes after the parser has settled
      repeat ($urandom_range(16, 40))
         file_bytes.push_back('{file_byte: 8'($urandom_range(0, 255)),
                                is_final: 1'($urandom_range(0, 1))});
      // short files are padded so every run streams a full load of bytes
      while (file_bytes.size() < TARGET_BYTES + 50)
         file_bytes.push_back('{file_byte: 8'($urandom_range(0, 255)),
                                is_final: 1'($urandom_range(0, 1))});
      file_length = file_bytes.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < file_length) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("streamed %0d file bytes with %0d chunk headers, checked %0d results",
               file_length, chunk_count, results_checked);
      $display("stream ending %s, parser settled on %s", ending.name(), mir_latched.name());
      if (mismatch_count == 0)
         $display("tb_wav_header_chunk_parser: done, clean");
      else
         $display("tb_wav_header_chunk_parser: done, errors");
      $finish;
   end

endmodule
